>>> rtl/jts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner package
// Shared types, character codes and sizes for the token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

   // token kinds carried on the result channel
   typedef enum logic [2:0] {
      KindPunct    = 3'd0,
      KindStrByte  = 3'd1,
      KindStrEnd   = 3'd2,
      KindNameByte = 3'd3,
      KindNameEnd  = 3'd4,
      KindInteger  = 3'd5,
      KindReal     = 3'd6,
      KindEof      = 3'd7
   } kind_type;

   // scanner states
   typedef enum logic [2:0] {
      ScanIdle    = 3'd0,
      ScanString  = 3'd1,
      ScanName    = 3'd2,
      ScanInteger = 3'd3,
      ScanReal    = 3'd4
   } scan_type;

   localparam int NumberWidth = 64;
   localparam int FracWidth   = 6;
   localparam logic [FracWidth-1:0] FracMax = 6'd63;

   // character codes
   localparam logic [7:0] CharZero     = 8'h30;
   localparam logic [7:0] CharNine     = 8'h39;
   localparam logic [7:0] CharSpace    = 8'h20;
   localparam logic [7:0] CharHighBase = 8'h80;
   localparam logic [7:0] CharLowA     = 8'h61;
   localparam logic [7:0] CharLowZ     = 8'h7a;
   localparam logic [7:0] CharMinus    = 8'h2d;
   localparam logic [7:0] CharDot      = 8'h2e;
   localparam logic [7:0] CharQuote    = 8'h22;
   localparam logic [7:0] CharLBrack   = 8'h5b;
   localparam logic [7:0] CharRBrack   = 8'h5d;
   localparam logic [7:0] CharLBrace   = 8'h7b;
   localparam logic [7:0] CharRBrace   = 8'h7d;
   localparam logic [7:0] CharColon    = 8'h3a;
   localparam logic [7:0] CharComma    = 8'h2c;

   // result word queue
   localparam int RspDepth      = 4;
   localparam int RspIdxWidth   = 2;
   localparam int RspCountWidth = 3;

   typedef struct packed {
      kind_type                      token_kind;
      logic [7:0]                    byte_value;
      logic signed [NumberWidth-1:0] number_value;
      logic [FracWidth-1:0]          fraction_digits;
      logic                          last_of_run;
   } rsp_word_type;

   // up to two result words produced by one input word
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } step_out_type;

endpackage
`default_nettype wire

>>> rtl/jts_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner request channel
// Valid/ready channel carrying one input byte or an end-of-input mark.
// ----------------------------------------------------------------------------
interface jts_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] char_byte;

   modport source (output valid, output mode, output char_byte, input ready);
   modport sink (input valid, input mode, input char_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/jts_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner response channel
// Valid/ready channel carrying one token event.
// ----------------------------------------------------------------------------
interface jts_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        token_kind;
   logic [7:0]        byte_value;
   logic signed [63:0] number_value;
   logic [5:0]        fraction_digits;
   logic              last_of_run;

   modport source (output valid, output token_kind, output byte_value,
                   output number_value, output fraction_digits,
                   output last_of_run, input ready);
   modport sink (input valid, input token_kind, input byte_value,
                 input number_value, input fraction_digits,
                 input last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/jts_scan_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner core
// Scan state, number accumulator and the per-byte step logic.
// ----------------------------------------------------------------------------
module jts_scan_core #(
   parameter int ACCUMULATOR_WIDTH = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step_valid,
   input  wire                   step_mode,
   input  wire [7:0]             step_byte,
   output jts_pkg::step_out_type step_out
);

   localparam int AccWidth = ACCUMULATOR_WIDTH;

   jts_pkg::scan_type state_ff, state_in;
   logic [AccWidth-1:0]          acc_ff, acc_in;
   logic                         neg_ff, neg_in;
   logic [jts_pkg::FracWidth-1:0] frac_ff, frac_in;

   logic is_digit, is_lower, is_punct, is_quote, is_minus, is_dot, is_name_start;
   logic idle_valid, run_idle;
   jts_pkg::scan_type idle_next;
   jts_pkg::rsp_word_type idle_word, pre_word;
   logic pre_valid;

   logic [AccWidth-1:0] digit_val, acc_step, fin_raw;
   logic signed [AccWidth-1:0] fin_s;
   logic signed [jts_pkg::NumberWidth-1:0] fin_num;

   // byte classes
   assign is_digit = (step_byte >= jts_pkg::CharZero) && (step_byte <= jts_pkg::CharNine);
   assign is_lower = (step_byte >= jts_pkg::CharLowA) && (step_byte <= jts_pkg::CharLowZ);
   assign is_quote = step_byte == jts_pkg::CharQuote;
   assign is_minus = step_byte == jts_pkg::CharMinus;
   assign is_dot   = step_byte == jts_pkg::CharDot;
   assign is_punct = (step_byte == jts_pkg::CharLBrack) || (step_byte == jts_pkg::CharRBrack) ||
                     (step_byte == jts_pkg::CharLBrace) || (step_byte == jts_pkg::CharRBrace) ||
                     (step_byte == jts_pkg::CharColon)  || (step_byte == jts_pkg::CharComma);
   assign is_name_start = (step_byte > jts_pkg::CharSpace) &&
                          (step_byte < jts_pkg::CharHighBase) &&
                          !is_quote && !is_minus && !is_digit;

   // number datapath: multiply by ten as shift-add, wrap at the accumulator width
   assign digit_val = AccWidth'(step_byte[3:0]);
   assign acc_step  = (acc_ff << 3) + (acc_ff << 1) + digit_val;
   assign fin_raw   = neg_ff ? (AccWidth'(0) - acc_ff) : acc_ff;
   assign fin_s     = fin_raw;
   assign fin_num   = jts_pkg::NumberWidth'(fin_s);

   // rescan of the byte from idle after a token ends
   always_comb begin
      unique case (state_ff)
         jts_pkg::ScanIdle:    run_idle = !step_mode;
         jts_pkg::ScanName:    run_idle = !step_mode && !is_lower;
         jts_pkg::ScanInteger: run_idle = !step_mode && !is_digit && !is_dot;
         jts_pkg::ScanReal:    run_idle = !step_mode && !is_digit;
         default:              run_idle = 1'b0;
      endcase
   end

   always_comb begin
      priority if (is_punct)      idle_next = jts_pkg::ScanIdle;
      else if (is_quote)          idle_next = jts_pkg::ScanString;
      else if (is_minus || is_digit) idle_next = jts_pkg::ScanInteger;
      else if (is_name_start)     idle_next = jts_pkg::ScanName;
      else                        idle_next = jts_pkg::ScanIdle;
   end

   // next state
   always_comb begin
      if (step_mode) begin
         state_in = jts_pkg::ScanIdle;
      end else begin
         unique case (state_ff)
            jts_pkg::ScanString:  state_in = is_quote ? jts_pkg::ScanIdle : jts_pkg::ScanString;
            jts_pkg::ScanName:    state_in = is_lower ? jts_pkg::ScanName : idle_next;
            jts_pkg::ScanInteger: state_in = is_digit ? jts_pkg::ScanInteger :
                                             is_dot ? jts_pkg::ScanReal : idle_next;
            jts_pkg::ScanReal:    state_in = is_digit ? jts_pkg::ScanReal : idle_next;
            default:              state_in = idle_next;
         endcase
      end
   end

   // number registers
   always_comb begin
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      frac_in = frac_ff;
      if (step_mode) begin
         acc_in  = '0;
         neg_in  = 1'b0;
         frac_in = '0;
      end else if (is_digit && (state_ff == jts_pkg::ScanInteger ||
                                state_ff == jts_pkg::ScanReal)) begin
         acc_in = acc_step;
         if (state_ff == jts_pkg::ScanReal && frac_ff != jts_pkg::FracMax) begin
            frac_in = frac_ff + 1'b1;
         end
      end else if (is_dot && state_ff == jts_pkg::ScanInteger) begin
         frac_in = '0;
      end else if (run_idle) begin
         acc_in  = is_digit ? digit_val : '0;
         neg_in  = is_minus;
         frac_in = '0;
      end
   end

   // result words
   always_comb begin
      idle_word                 = '0;
      idle_word.token_kind      = is_punct ? jts_pkg::KindPunct : jts_pkg::KindNameByte;
      idle_word.byte_value      = step_byte;
      idle_valid                = run_idle && (is_punct || is_name_start);

      pre_word  = '0;
      pre_valid = 1'b1;
      if (step_mode) begin
         pre_word.token_kind = jts_pkg::KindEof;
      end else begin
         unique case (state_ff)
            jts_pkg::ScanString: begin
               pre_word.token_kind = is_quote ? jts_pkg::KindStrEnd : jts_pkg::KindStrByte;
               pre_word.byte_value = is_quote ? 8'h00 : step_byte;
            end
            jts_pkg::ScanName: begin
               pre_word.token_kind = is_lower ? jts_pkg::KindNameByte : jts_pkg::KindNameEnd;
               pre_word.byte_value = is_lower ? step_byte : 8'h00;
            end
            jts_pkg::ScanInteger: begin
               pre_word.token_kind   = jts_pkg::KindInteger;
               pre_word.number_value = fin_num;
               pre_valid             = run_idle;
            end
            jts_pkg::ScanReal: begin
               pre_word.token_kind      = jts_pkg::KindReal;
               pre_word.number_value    = fin_num;
               pre_word.fraction_digits = frac_ff;
               pre_valid                = run_idle;
            end
            default: pre_valid = 1'b0;
         endcase
      end

      if (pre_valid) begin
         step_out.word0 = pre_word;
         step_out.word1 = idle_word;
         step_out.count = idle_valid ? 2'd2 : 2'd1;
      end else begin
         step_out.word0 = idle_word;
         step_out.word1 = idle_word;
         step_out.count = idle_valid ? 2'd1 : 2'd0;
      end
      step_out.word0.last_of_run = step_out.count == 2'd1;
      step_out.word1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jts_pkg::ScanIdle;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         frac_ff  <= '0;
      end else if (step_valid) begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         frac_ff  <= frac_in;
      end
   end

`ifndef SYNTHESIS
   a_number_clear_outside_number: assert property (@(posedge clock) disable iff (reset)
      (state_ff != jts_pkg::ScanInteger && state_ff != jts_pkg::ScanReal) |->
         (acc_ff == '0 && !neg_ff && frac_ff == '0))
      else $error("number state not clear outside a number");
   a_eof_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (step_valid && step_mode) |=> state_ff == jts_pkg::ScanIdle)
      else $error("end of input did not return to idle");
`endif

endmodule
`default_nettype wire

>>> rtl/jts_rsp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner response queue
// Small queue taking up to two words per cycle, giving one per cycle on ready.
// ----------------------------------------------------------------------------
module jts_rsp_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push_valid,
   input  wire jts_pkg::step_out_type push_data,
   output logic                       room,
   output logic                       out_valid,
   input  wire                        out_ready,
   output jts_pkg::rsp_word_type      out_word
);

   jts_pkg::rsp_word_type entry_ff [jts_pkg::RspDepth];
   logic [jts_pkg::RspIdxWidth-1:0]   head_ff, head_in, tail0, tail1;
   logic [jts_pkg::RspCountWidth-1:0] count_ff, count_in;
   logic [1:0] push_n;
   logic       pop;

   assign push_n    = push_valid ? push_data.count : 2'd0;
   assign out_valid = count_ff != '0;
   assign pop       = out_valid && out_ready;
   assign out_word  = entry_ff[head_ff];
   // keep space for the worst case of two words
   assign room      = count_ff <= jts_pkg::RspCountWidth'(jts_pkg::RspDepth - 2);
   assign tail0     = head_ff + count_ff[jts_pkg::RspIdxWidth-1:0];
   assign tail1     = tail0 + 1'b1;
   assign head_in   = pop ? head_ff + 1'b1 : head_ff;
   assign count_in  = count_ff + jts_pkg::RspCountWidth'(push_n)
                      - jts_pkg::RspCountWidth'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[tail0] <= push_data.word0;
      end
      if (push_n == 2'd2) begin
         entry_ff[tail1] <= push_data.word1;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |->
         (count_ff <= jts_pkg::RspCountWidth'(jts_pkg::RspDepth - 2)))
      else $error("response queue push without room");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && push_n == 2'd0) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("response queue count did not drop on pop");
`endif

endmodule
`default_nettype wire

>>> rtl/json_token_scanner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner
// Streaming JSON lexer: one byte in per word, token events out.
// ----------------------------------------------------------------------------
// The scanner takes one byte (or an end-of-input mark) per request word and
// sustains one word per cycle while the response queue has room. A byte
// passes an input register, then the step logic (byte classes, scan state,
// and a multiply-by-ten accumulator built as a shift-add) that writes zero,
// one or two token words into a four-entry response queue. A byte that ends
// a number or a name and then starts a punctuation or name token gives two
// response words, so a steady run of such bytes drains at the response
// side's one word per cycle; the queue keeps taking bytes as long as it has
// room for two words. Numbers come out as a signed mantissa, wrapped at
// ACCUMULATOR_WIDTH bits and sign-extended to 64, plus a count of fraction
// digits that saturates at 63. End of input always gives an EOF word, drops
// any unfinished token and returns the scanner to idle. The last word
// caused by a byte carries last_of_run.
// ----------------------------------------------------------------------------
module json_token_scanner_top #(
   parameter int ACCUMULATOR_WIDTH = 64
) (
   input wire          clock,
   input wire          reset,
   jts_req_if.sink     req_ch,
   jts_rsp_if.source   rsp_ch
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_mode_ff;
   logic [7:0] in_byte_ff;
   logic       req_fire, step_fire, q_room;

   jts_pkg::step_out_type step_out;
   jts_pkg::rsp_word_type head_word;

   // advance the held word into the queue whenever it has room for two words
   assign step_fire    = in_valid_ff && q_room;
   assign req_ch.ready = !in_valid_ff || step_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold payload until the step logic takes it
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff <= req_ch.mode;
         in_byte_ff <= req_ch.char_byte;
      end
   end

   jts_scan_core #(
      .ACCUMULATOR_WIDTH (ACCUMULATOR_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_fire),
      .step_mode  (in_mode_ff),
      .step_byte  (in_byte_ff),
      .step_out   (step_out)
   );

   jts_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (step_fire),
      .push_data  (step_out),
      .room       (q_room),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_word   (head_word)
   );

   // drive response payload from the queue head
   assign rsp_ch.token_kind      = head_word.token_kind;
   assign rsp_ch.byte_value      = head_word.byte_value;
   assign rsp_ch.number_value    = head_word.number_value;
   assign rsp_ch.fraction_digits = head_word.fraction_digits;
   assign rsp_ch.last_of_run     = head_word.last_of_run;

endmodule
`default_nettype wire

>>> sim/jts_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token scanner checker
// Watches both channels, predicts the token words of every accepted byte and
// compares each returned word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module jts_token_checker import jts_pkg::*; #(
   parameter int AccWidth = 64
) (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_valid,
   input wire                      req_ready,
   input wire                      req_mode,
   input wire [7:0]                req_char,
   input wire                      rsp_valid,
   input wire                      rsp_ready,
   input wire [2:0]                rsp_kind,
   input wire [7:0]                rsp_byte,
   input wire signed [NumberWidth-1:0] rsp_number,
   input wire [FracWidth-1:0]      rsp_frac,
   input wire                      rsp_last,
   output int                      mismatch_count,
   output int                      tokens_outstanding
);

   localparam logic [NumberWidth-1:0] AccMask = {NumberWidth{1'b1}} >> (NumberWidth - AccWidth);
   localparam logic [NumberWidth-1:0] AccTop  = AccMask ^ (AccMask >> 1);
   localparam int DecimalBase = 10;

   // scanner copy
   scan_type               scan_now;
   logic [NumberWidth-1:0] digits_acc;
   logic                   minus_seen;
   logic [FracWidth-1:0]   frac_seen;

   rsp_word_type expected_tokens[$];
   rsp_word_type step_words[0:1];
   int           step_count;

   initial begin
      mismatch_count     = 0;
      tokens_outstanding = 0;
   end

   task automatic clear_number();
      digits_acc = '0;
      minus_seen = 1'b0;
      frac_seen  = '0;
   endtask

   task automatic push_token(kind_type kind, logic [7:0] b, logic [NumberWidth-1:0] num,
                             logic [FracWidth-1:0] frac);
      rsp_word_type w;
      w.token_kind      = kind;
      w.byte_value      = b;
      w.number_value    = num;
      w.fraction_digits = frac;
      w.last_of_run     = 1'b0;
      step_words[step_count] = w;
      step_count++;
   endtask

   function automatic logic [NumberWidth-1:0] finished_number();
      logic [NumberWidth-1:0] v;
      v = digits_acc & AccMask;
      if (minus_seen) v = (~v + 1'b1) & AccMask;
      if ((v & AccTop) != 0) v = v | ~AccMask;
      return v;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= CharZero && c <= CharNine;
   endfunction

   task automatic add_digit(logic [7:0] c);
      digits_acc = (digits_acc * DecimalBase + NumberWidth'(c - CharZero)) & AccMask;
   endtask

   task automatic scan_from_idle(logic [7:0] c);
      scan_now = ScanIdle;
      case (c)
         CharLBrack, CharRBrack, CharLBrace, CharRBrace, CharColon, CharComma: begin
            push_token(KindPunct, c, '0, '0);
         end
         CharQuote: begin
            scan_now = ScanString;
         end
         default: begin
            if (c == CharMinus) begin
               clear_number();
               minus_seen = 1'b1;
               scan_now   = ScanInteger;
            end else if (is_digit(c)) begin
               clear_number();
               digits_acc = NumberWidth'(c - CharZero) & AccMask;
               scan_now   = ScanInteger;
            end else if (c > CharSpace && c < CharHighBase) begin
               scan_now = ScanName;
               push_token(KindNameByte, c, '0, '0);
            end
         end
      endcase
   endtask

   task automatic predict_word(logic mode, logic [7:0] c);
      step_count = 0;
      if (mode) begin
         scan_now = ScanIdle;
         clear_number();
         push_token(KindEof, '0, '0, '0);
      end else begin
         case (scan_now)
            ScanString: begin
               if (c == CharQuote) begin
                  scan_now = ScanIdle;
                  push_token(KindStrEnd, '0, '0, '0);
               end else begin
                  push_token(KindStrByte, c, '0, '0);
               end
            end
            ScanName: begin
               if (c >= CharLowA && c <= CharLowZ) begin
                  push_token(KindNameByte, c, '0, '0);
               end else begin
                  push_token(KindNameEnd, '0, '0, '0);
                  scan_from_idle(c);
               end
            end
            ScanInteger: begin
               if (is_digit(c)) begin
                  add_digit(c);
               end else if (c == CharDot) begin
                  scan_now  = ScanReal;
                  frac_seen = '0;
               end else begin
                  push_token(KindInteger, '0, finished_number(), '0);
                  clear_number();
                  scan_from_idle(c);
               end
            end
            ScanReal: begin
               if (is_digit(c)) begin
                  add_digit(c);
                  if (frac_seen < FracMax) frac_seen = frac_seen + 1'b1;
               end else begin
                  push_token(KindReal, '0, finished_number(), frac_seen);
                  clear_number();
                  scan_from_idle(c);
               end
            end
            default: begin
               scan_from_idle(c);
            end
         endcase
      end
      // mark the final word of this byte
      if (step_count > 0) step_words[step_count-1].last_of_run = 1'b1;
      for (int i = 0; i < step_count; i++) expected_tokens.push_back(step_words[i]);
   endtask

   task automatic check_word();
      rsp_word_type w;
      if (expected_tokens.size() == 0) begin
         $error("unexpected token word: token_kind %0d byte_value %0h", rsp_kind, rsp_byte);
         mismatch_count++;
      end else begin
         w = expected_tokens.pop_front();
         if (rsp_kind !== w.token_kind) begin
            $error("token_kind: expected %0d, got %0d", w.token_kind, rsp_kind);
            mismatch_count++;
         end
         if (rsp_byte !== w.byte_value) begin
            $error("byte_value: expected %0h, got %0h", w.byte_value, rsp_byte);
            mismatch_count++;
         end
         if (rsp_number !== w.number_value) begin
            $error("number_value: expected %0d, got %0d", w.number_value, rsp_number);
            mismatch_count++;
         end
         if (rsp_frac !== w.fraction_digits) begin
            $error("fraction_digits: expected %0d, got %0d", w.fraction_digits, rsp_frac);
            mismatch_count++;
         end
         if (rsp_last !== w.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", w.last_of_run, rsp_last);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_now = ScanIdle;
         clear_number();
         expected_tokens.delete();
      end else begin
         // predict first so a word returned in the same cycle as its request would still find its entry
         if (req_valid && req_ready) predict_word(req_mode, req_char);
         if (rsp_valid && rsp_ready) check_word();
      end
      tokens_outstanding = expected_tokens.size();
   end

endmodule

>>> sim/tb_json_token_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token scanner testbench
// Feeds directed and random byte streams into the scanner with random idle
// and stall cycles; a checker beside the block predicts and compares tokens.
// ----------------------------------------------------------------------------
module tb_json_token_scanner_top;
   import jts_pkg::*;

   localparam int AccWidth     = 64;
   localparam int RandomWords  = 1650;
   localparam int IdlePct      = 6;
   localparam int CalmFirst    = 700;   // no idling or stalls in this window
   localparam int CalmLast     = 1000;
   localparam int DrainCycles  = 8;

   logic clock;
   logic reset;
   logic calm_window;
   int   words_counted;
   int   mismatch_count;
   int   tokens_outstanding;

   jts_req_if req_if ();
   jts_rsp_if rsp_if ();

   json_token_scanner_top #(
      .ACCUMULATOR_WIDTH(AccWidth)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   jts_token_checker #(
      .AccWidth(AccWidth)
   ) token_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_if.valid),
      .req_ready          (req_if.ready),
      .req_mode           (req_if.mode),
      .req_char           (req_if.char_byte),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_kind           (rsp_if.token_kind),
      .rsp_byte           (rsp_if.byte_value),
      .rsp_number         (rsp_if.number_value),
      .rsp_frac           (rsp_if.fraction_digits),
      .rsp_last           (rsp_if.last_of_run),
      .mismatch_count     (mismatch_count),
      .tokens_outstanding (tokens_outstanding)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // stall the result side at random, never inside the calm window
   always @(negedge clock) begin
      rsp_if.ready = calm_window || ($urandom_range(0, 99) >= IdlePct);
   end

   // Drive one word at the falling edge and hold it until accepted. Idle
   // cycles go in front of the word; valid stays high between back-to-back
   // words.
   task automatic send_word(logic mode, logic [7:0] c, bit counted);
      while (!calm_window && $urandom_range(0, 99) < IdlePct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.mode      = mode;
      req_if.char_byte = c;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      if (counted) begin
         words_counted++;
         calm_window = words_counted >= CalmFirst && words_counted < CalmLast;
      end
   endtask

   task automatic send_byte(logic [7:0] c);
      send_word(1'b0, c, 1'b1);
   endtask

   // end of input carries a random byte, which the block must ignore
   task automatic send_eof();
      send_word(1'b1, 8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_digits(int count);
      for (int i = 0; i < count; i++) send_byte(CharZero + 8'($urandom_range(0, 9)));
   endtask

   // Emit one random token: mostly well-formed punctuation, strings, names
   // and numbers, with some whitespace, end marks and raw noise mixed in.
   task automatic emit_random_token();
      int         pick;
      int         len;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         case ($urandom_range(0, 5))
            0: c = CharLBrack;
            1: c = CharRBrack;
            2: c = CharLBrace;
            3: c = CharRBrace;
            4: c = CharColon;
            default: c = CharComma;
         endcase
         send_byte(c);
      end else if (pick < 30) begin
         // string: any content but the quote
         send_byte(CharQuote);
         len = $urandom_range(0, 6);
         for (int i = 0; i < len; i++) begin
            do c = 8'($urandom_range(0, 255)); while (c == CharQuote);
            send_byte(c);
         end
         if ($urandom_range(0, 9) != 0) send_byte(CharQuote);
      end else if (pick < 45) begin
         // bare name: a starter byte from 8'h21 to 8'h7f, then lowercase
         send_byte(8'($urandom_range(8'h21, 8'h7f)));
         len = $urandom_range(0, 5);
         for (int i = 0; i < len; i++) send_byte(CharLowA + 8'($urandom_range(0, 25)));
      end else if (pick < 62) begin
         // integer; now and then long enough to wrap the accumulator
         if ($urandom_range(0, 9) < 3) send_byte(CharMinus);
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 5);
         send_digits(len);
      end else if (pick < 76) begin
         // real; now and then long enough to saturate the fraction count
         if ($urandom_range(0, 9) < 3) send_byte(CharMinus);
         send_digits($urandom_range(1, 3));
         send_byte(CharDot);
         len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 4);
         send_digits(len);
      end else if (pick < 84) begin
         // whitespace or high byte: skipped in idle, so not counted
         c = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 32))
                                          : 8'($urandom_range(128, 255));
         send_word(1'b0, c, 1'b0);
      end else if (pick < 87) begin
         send_eof();
      end else begin
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      reset            = 1'b1;
      calm_window      = 1'b0;
      words_counted    = 0;
      req_if.valid     = 1'b0;
      req_if.mode      = 1'b0;
      req_if.char_byte = 8'h00;
      rsp_if.ready     = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // punctuation, one of each
      send_byte(CharLBrack);
      send_byte(CharRBrack);
      send_byte(CharLBrace);
      send_byte(CharRBrace);
      send_byte(CharColon);
      send_byte(CharComma);
      // string holding the byte extremes
      send_byte(CharQuote);
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(CharQuote);
      // skipped bytes at the edges of the skip ranges
      send_byte(CharSpace);
      send_byte(CharHighBase);
      // name starting on the top name-start byte, ended by punctuation
      send_byte(8'h7f);
      send_byte(CharLowZ);
      send_byte(CharComma);
      // lone minus gives integer zero
      send_byte(CharMinus);
      send_byte(CharRBrack);
      // dot with no fraction digits
      send_byte(CharZero + 8'd1);
      send_byte(CharDot);
      send_byte(CharRBrace);
      // second dot ends the real and starts a name
      send_byte(CharNine);
      send_byte(CharDot);
      send_byte(CharZero + 8'd5);
      send_byte(CharDot);
      // end of input drops the open name
      send_eof();
      // end of input inside a number and inside a string
      send_byte(CharMinus);
      send_byte(CharNine);
      send_eof();
      send_byte(CharQuote);
      send_eof();

      words_counted = 0;
      while (words_counted < RandomWords) emit_random_token();
      req_if.valid = 1'b0;

      // drain: wait for every predicted word, then a few quiet cycles
      while (tokens_outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
